// ----- design/oafb_pkg.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder package
// Frame constants, the job record passed from the front to the back, and
// the byte-wide CRC-16 update used by the front.
// ---------------------------------------------------------------------------
`default_nettype none

package oafb_pkg;

    // frame bytes
    localparam logic [7:0] FRAME_START0 = 8'h90;
    localparam logic [7:0] FRAME_START1 = 8'h02;
    localparam logic [7:0] OP_WRITE     = 8'h68;
    localparam logic [7:0] OP_READ      = 8'h60;
    localparam logic [7:0] LEN_WRITE    = 8'h04;
    localparam logic [7:0] LEN_READ     = 8'h02;
    localparam logic [7:0] SUBINDEX     = 8'h00;

    // CRC-16, polynomial 0x1021, MSB first
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // CRC byte steps per frame (payload words plus the appended zero word)
    localparam logic [3:0] STEPS_READ  = 4'd8;
    localparam logic [3:0] STEPS_WRITE = 4'd12;

    // position of the CRC high byte
    localparam logic [3:0] LAST_POS_READ  = 4'd9;
    localparam logic [3:0] LAST_POS_WRITE = 4'd13;

    // one classified request with its finished CRC
    typedef struct packed {
        logic        is_write;
        logic [15:0] index;
        logic [31:0] value;
        logic [7:0]  node;
        logic [15:0] crc;
    } t_job;

    // shift one byte into the CRC, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        logic        carry;
        c = crc_in;
        for (int b = 7; b >= 0; b--) begin
            carry = c[15];
            c     = {c[14:0], data[b]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/oafb_ifs.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder channels
// Valid/ready channels for requests, frame bytes and the node id write.
// ---------------------------------------------------------------------------
`default_nettype none

// request channel
interface oafb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] object_index;
    logic [31:0] write_value;

    modport source (output valid, output req_type, output object_index,
                    output write_value, input ready);
    modport sink   (input valid, input req_type, input object_index,
                    input write_value, output ready);
endinterface

// frame byte channel
interface oafb_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// node id write channel
interface oafb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] node_id;

    modport source (output valid, output node_id, input ready);
    modport sink   (input valid, input node_id, output ready);
endinterface

`default_nettype wire

// ----- design/oafb_front.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder front end
// Accepts a request, latches it with the node id and runs the CRC over the
// payload one byte per cycle, then hands the job to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module oafb_front
    import oafb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_node_id,
    oafb_req_if.sink        i_req,
    output t_job            o_job,
    output logic            o_job_valid,
    input  wire logic       i_job_ready
);

    logic        r_busy;
    logic [3:0]  r_step;
    logic [15:0] r_crc;
    logic        r_is_write;
    logic [15:0] r_index;
    logic [31:0] r_value;
    logic [7:0]  r_node;

    logic       done;
    logic       push;
    logic       accept;
    logic [3:0] steps_end;
    logic [7:0] crc_in;

    assign steps_end   = r_is_write ? STEPS_WRITE : STEPS_READ;
    assign done        = r_busy && (r_step == steps_end);
    assign push        = done && i_job_ready;
    assign i_req.ready = !r_busy || push;
    assign accept      = i_req.valid && i_req.ready;

    // byte fed to the CRC: each little-endian word goes high byte first
    always_comb begin
        case (r_step)
            4'd0:    crc_in = r_is_write ? LEN_WRITE : LEN_READ;
            4'd1:    crc_in = r_is_write ? OP_WRITE : OP_READ;
            4'd2:    crc_in = r_index[7:0];
            4'd3:    crc_in = r_node;
            4'd4:    crc_in = SUBINDEX;
            4'd5:    crc_in = r_index[15:8];
            4'd6:    crc_in = r_is_write ? r_value[15:8] : 8'h00;
            4'd7:    crc_in = r_is_write ? r_value[7:0] : 8'h00;
            4'd8:    crc_in = r_value[31:24];
            4'd9:    crc_in = r_value[23:16];
            default: crc_in = 8'h00;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (push) begin
            r_busy <= 1'b0;
        end else if (r_busy && !done) begin
            r_step <= r_step + 4'd1;
        end
    end

    // payload and CRC
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_write <= i_req.req_type;
            r_index    <= i_req.object_index;
            r_value    <= i_req.write_value;
            r_node     <= i_node_id;
            r_crc      <= CRC_INIT;
        end else if (r_busy && !done) begin
            r_crc <= crc_byte(r_crc, crc_in);
        end
    end

    assign o_job_valid    = done;
    assign o_job.is_write = r_is_write;
    assign o_job.index    = r_index;
    assign o_job.value    = r_value;
    assign o_job.node     = r_node;
    assign o_job.crc      = r_crc;

endmodule

`default_nettype wire

// ----- design/oafb_queue.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder job queue
// Small FIFO of finished jobs between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module oafb_queue
    import oafb_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_push_job,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    output t_job      o_head,
    output logic      o_head_valid,
    input  wire logic i_pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

`ifndef ASSERT_OFF
    // fill count never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    // a lone push grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count did not grow on push");

    // a waiting head stays put until popped
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_valid && !i_pop_ready |=> $stable(o_head))
        else $error("queue head changed while held");
`endif

endmodule

`default_nettype wire

// ----- design/oafb_back.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder back end
// Takes jobs from the queue and sends the frame one byte per item, flagging
// the CRC high byte as the last.
// ---------------------------------------------------------------------------
`default_nettype none

module oafb_back
    import oafb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    oafb_frm_if.source o_frm
);

    logic       r_active;
    logic [3:0] r_pos;
    t_job       r_job;

    logic       fire;
    logic       is_last;
    logic       load;
    logic [3:0] last_pos;
    logic [7:0] tail_byte;

    assign last_pos    = r_job.is_write ? LAST_POS_WRITE : LAST_POS_READ;
    assign is_last     = (r_pos == last_pos);
    assign fire        = r_active && o_frm.ready;
    assign o_job_ready = !r_active || (fire && is_last);
    assign load        = i_job_valid && o_job_ready;

    // bytes after the subindex: value bytes on writes, then the CRC
    always_comb begin
        if (r_job.is_write) begin
            case (r_pos)
                4'd8:    tail_byte = r_job.value[7:0];
                4'd9:    tail_byte = r_job.value[15:8];
                4'd10:   tail_byte = r_job.value[23:16];
                4'd11:   tail_byte = r_job.value[31:24];
                4'd12:   tail_byte = r_job.crc[7:0];
                default: tail_byte = r_job.crc[15:8];
            endcase
        end else begin
            tail_byte = (r_pos == 4'd8) ? r_job.crc[7:0] : r_job.crc[15:8];
        end
    end

    // frame byte select
    always_comb begin
        case (r_pos)
            4'd0:    o_frm.frame_byte = FRAME_START0;
            4'd1:    o_frm.frame_byte = FRAME_START1;
            4'd2:    o_frm.frame_byte = r_job.is_write ? OP_WRITE : OP_READ;
            4'd3:    o_frm.frame_byte = r_job.is_write ? LEN_WRITE : LEN_READ;
            4'd4:    o_frm.frame_byte = r_job.node;
            4'd5:    o_frm.frame_byte = r_job.index[7:0];
            4'd6:    o_frm.frame_byte = r_job.index[15:8];
            4'd7:    o_frm.frame_byte = SUBINDEX;
            default: o_frm.frame_byte = tail_byte;
        endcase
    end

    assign o_frm.valid     = r_active;
    assign o_frm.last_byte = is_last;

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (load) begin
            r_active <= 1'b1;
            r_pos    <= '0;
        end else if (fire && is_last) begin
            r_active <= 1'b0;
        end else if (fire) begin
            r_pos <= r_pos + 4'd1;
        end
    end

    // job holding register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

`ifndef ASSERT_OFF
    // position never runs past the CRC high byte
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_pos <= last_pos)
        else $error("frame position beyond last byte");

    // a taken mid-frame byte advances the position by one
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !is_last |=> r_active && r_pos == $past(r_pos) + 4'd1)
        else $error("frame position did not advance");

    // a loaded job starts at the first start byte
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_active && r_pos == '0)
        else $error("new frame did not start at position zero");
`endif

endmodule

`default_nettype wire

// ----- design/object_access_frame_builder_top.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder
// Turns read/write object requests into serial-link frames, byte by byte.
//
// Channels: i_req takes one request item (req_type, object_index,
// write_value); o_frm gives one frame byte per item, last_byte set on the
// CRC high byte; i_cfg writes the node id and is always ready.
// A read frame is 10 bytes, a write frame 14 bytes.
// The front latches a request, runs 8 CRC byte steps (12 for a write) and
// pushes the job into the queue; the back loads it and sends the frame.
// Throughput: the back sends one byte per cycle with a ready receiver;
// the front finishes a job sooner than the back sends a frame of the same
// kind, so back-to-back requests of one kind keep the output busy every
// cycle. The job queue lets the front finish the next CRC while the back
// waits.
// Reset: synchronous, active low; empties the queue, drops any frame in
// flight and sets the node id to 1.
// A stalled receiver holds the current byte; the queue then fills and the
// request channel drops ready.
// ---------------------------------------------------------------------------
`default_nettype none

module object_access_frame_builder_top
    import oafb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oafb_cfg_if.sink   i_cfg,
    oafb_req_if.sink   i_req,
    oafb_frm_if.source o_frm
);

    logic [7:0] r_node_id;

    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job head_job;
    logic head_valid;
    logic head_ready;

    // node id register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= 8'h01;
        end else if (i_cfg.valid) begin
            r_node_id <= i_cfg.node_id;
        end
    end

    oafb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_node_id   (r_node_id),
        .i_req       (i_req),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    oafb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_job   (front_job),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_head       (head_job),
        .o_head_valid (head_valid),
        .i_pop_ready  (head_ready)
    );

    oafb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_job_ready (head_ready),
        .o_frm       (o_frm)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// Object access frame builder testbench
// Drives read and write object requests and node id writes into the frame
// builder and checks every frame byte and last-byte flag against a frame
// predictor kept in the bench. A short directed table runs first, then
// random requests under three idling patterns on the two sides.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
    import oafb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DRAIN_CYCLES = 40;
    localparam int  PHASE_ITEMS  = 124;
    localparam time TIMEOUT_NS   = 3_000_000;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // one directed row; for ROW_CFG the node id sits in value[7:0]
    typedef struct packed {
        t_row_kind   kind;
        logic        is_write;
        logic [15:0] index;
        logic [31:0] value;
        logic        typed;
        logic [7:0]  exp_node;
    } t_dir_row;

    // one expected frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_beat;

    localparam int DIR_ROWS = 17;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // after reset: node id 1
        '{ROW_REQ, 1'b0, 16'h0000, 32'h0000_0000, 1'b1, 8'h01},
        '{ROW_REQ, 1'b1, 16'h0000, 32'h0000_0000, 1'b1, 8'h01},
        // read carrying a value that must be ignored
        '{ROW_REQ, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'h01},
        '{ROW_REQ, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'h01},
        '{ROW_REQ, 1'b1, 16'h1234, 32'h8000_0001, 1'b0, 8'h00},
        '{ROW_REQ, 1'b0, 16'h8000, 32'h0000_0000, 1'b0, 8'h00},
        '{ROW_REQ, 1'b0, 16'h0001, 32'hA5A5_A5A5, 1'b0, 8'h00},
        // lowest node id
        '{ROW_CFG, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 8'h00},
        '{ROW_REQ, 1'b0, 16'h0000, 32'h0000_0000, 1'b1, 8'h00},
        '{ROW_REQ, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'h00},
        // highest node id
        '{ROW_CFG, 1'b0, 16'h0000, 32'h0000_00FF, 1'b0, 8'h00},
        '{ROW_REQ, 1'b0, 16'hFFFF, 32'h0000_0000, 1'b1, 8'hFF},
        '{ROW_REQ, 1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b1, 8'hFF},
        '{ROW_REQ, 1'b1, 16'h00FF, 32'h00FF_00FF, 1'b0, 8'h00},
        // back to the reset value
        '{ROW_CFG, 1'b0, 16'h0000, 32'h0000_0001, 1'b0, 8'h00},
        '{ROW_REQ, 1'b0, 16'h1000, 32'h1234_5678, 1'b0, 8'h00},
        '{ROW_REQ, 1'b1, 16'h5A5A, 32'hDEAD_BEEF, 1'b0, 8'h00}
    };

    logic i_clk;
    logic i_rst_n;

    oafb_cfg_if cfg_ch ();
    oafb_req_if req_ch ();
    oafb_frm_if frm_ch ();

    object_access_frame_builder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_frm   (frm_ch)
    );

    t_frame_beat frame_beats_q [$];
    logic [7:0]  node_id_shadow;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          mismatches;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("object_access_frame_builder_top verification failed");
        $finish;
    end

    // CRC-16 step over one 16-bit word, MSB first, poly 0x1021
    function automatic logic [15:0] crc_shift_word(input logic [15:0] crc,
                                                   input logic [15:0] word);
        logic [15:0] c;
        logic        carry;
        c = crc;
        for (int i = 15; i >= 0; i--) begin
            carry = c[15];
            c     = {c[14:0], word[i]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // build the expected frame for one request and queue its bytes
    task automatic queue_frame(input logic is_write, input logic [15:0] index,
                               input logic [31:0] value, input logic typed,
                               input logic [7:0] exp_node);
        logic [7:0]  fb [14];
        int          n;
        int          base;
        logic [15:0] crc;
        t_frame_beat beat;
        n      = 0;
        base   = frame_beats_q.size();
        fb[0]  = FRAME_START0;
        fb[1]  = FRAME_START1;
        fb[2]  = is_write ? OP_WRITE : OP_READ;
        fb[3]  = is_write ? LEN_WRITE : LEN_READ;
        fb[4]  = node_id_shadow;
        fb[5]  = index[7:0];
        fb[6]  = index[15:8];
        fb[7]  = SUBINDEX;
        n      = 8;
        if (is_write) begin
            fb[8]  = value[7:0];
            fb[9]  = value[15:8];
            fb[10] = value[23:16];
            fb[11] = value[31:24];
            n      = 12;
        end
        // byte pairs from the opcode on, little-endian words, then a zero word
        crc = CRC_INIT;
        for (int i = 2; i + 1 < n; i += 2) begin
            crc = crc_shift_word(crc, {fb[i+1], fb[i]});
        end
        crc       = crc_shift_word(crc, 16'h0000);
        fb[n]     = crc[7:0];
        fb[n + 1] = crc[15:8];
        n         = n + 2;
        for (int k = 0; k < n; k++) begin
            beat.frame_byte = fb[k];
            beat.last_byte  = (k == n - 1);
            frame_beats_q.push_back(beat);
        end
        // header bytes known by inspection
        if (typed) begin
            frame_beats_q[base + 2].frame_byte = is_write ? OP_WRITE : OP_READ;
            frame_beats_q[base + 3].frame_byte = is_write ? LEN_WRITE : LEN_READ;
            frame_beats_q[base + 4].frame_byte = exp_node;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                   input logic [7:0] got_v);
        $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what,
                 exp_v, got_v);
        mismatches++;
    endtask

    // offer one request item, with random idle cycles ahead of it
    task automatic send_request(input logic is_write, input logic [15:0] index,
                                input logic [31:0] value, input logic typed,
                                input logic [7:0] exp_node);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.req_type     = is_write;
        req_ch.object_index = index;
        req_ch.write_value  = value;
        do @(posedge i_clk); while (!req_ch.ready);
        queue_frame(is_write, index, value, typed, exp_node);
        @(negedge i_clk);
    endtask

    // node id write, only once every frame has left the block
    task automatic write_node_id(input logic [7:0] node);
        req_ch.valid = 1'b0;
        while (frame_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid   = 1'b1;
        cfg_ch.node_id = node;
        do @(posedge i_clk); while (!cfg_ch.ready);
        node_id_shadow = node;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // receiver: ready changes on the falling edge
    initial begin
        frm_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            frm_ch.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // frame byte checker
    always @(posedge i_clk) begin
        t_frame_beat exp_beat;
        if (i_rst_n && frm_ch.valid && frm_ch.ready) begin
            if (frame_beats_q.size() == 0) begin
                // a byte with no item expected
                report_mismatch("unexpected frame_byte", 8'h00, frm_ch.frame_byte);
            end else begin
                exp_beat = frame_beats_q.pop_front();
                if (frm_ch.frame_byte !== exp_beat.frame_byte) begin
                    report_mismatch("frame_byte", exp_beat.frame_byte,
                                    frm_ch.frame_byte);
                end
                if (frm_ch.last_byte !== exp_beat.last_byte) begin
                    report_mismatch("last_byte", {7'd0, exp_beat.last_byte},
                                    {7'd0, frm_ch.last_byte});
                end
            end
        end
    end

    // main sequence
    initial begin
        logic [15:0] rnd_index;
        mismatches          = 0;
        node_id_shadow      = 8'h01;
        snd_idle_pct        = 32;
        rcv_idle_pct        = 78;
        i_rst_n             = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.node_id      = 8'h00;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = 1'b0;
        req_ch.object_index = 16'h0000;
        req_ch.write_value  = 32'h0000_0000;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].kind == ROW_CFG) begin
                write_node_id(DIR_TAB[r].value[7:0]);
            end else begin
                send_request(DIR_TAB[r].is_write, DIR_TAB[r].index,
                             DIR_TAB[r].value, DIR_TAB[r].typed,
                             DIR_TAB[r].exp_node);
            end
        end

        // random requests: slow receiver, then slow sender, then no idling
        for (int ph = 0; ph < 3; ph++) begin
            write_node_id(8'($urandom_range(0, 255)));
            snd_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
            rcv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // index extremes now and then
                case ($urandom_range(0, 15))
                    0:       rnd_index = 16'h0000;
                    1:       rnd_index = 16'hFFFF;
                    default: rnd_index = 16'($urandom);
                endcase
                send_request(1'($urandom_range(0, 1)), rnd_index, $urandom,
                             1'b0, 8'h00);
            end
        end

        // drain and finish
        req_ch.valid = 1'b0;
        while (frame_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("object_access_frame_builder_top verification clean");
        end else begin
            $display("object_access_frame_builder_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/oafb_pkg.sv
design/oafb_ifs.sv
design/oafb_front.sv
design/oafb_queue.sv
design/oafb_back.sv
design/object_access_frame_builder_top.sv
tb/tb_top.sv
